>>> design/ultrasonic_range_zone_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Ultrasonic range zone tracker - assertion macros
// Shorthand for the concurrent checks at the end of the top level. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_ZONE_TRACKER_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGE_ZONE_TRACKER_UNIT_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define URZT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Whenever ante holds, cons must hold at the same edge.
`define URZT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons must hold at the following edge.
`define URZT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/urzt_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic range zone tracker - shared definitions
// Register indexes, field widths, reset values and the control group passed
// from the measurement sequencer to the top level.
// ----------------------------------------------------------------------------
package urzt_pkg;

  localparam int COUNT_BITS_DEF = 16;

  // Echo time per centimetre of range, in microsecond ticks.
  localparam int US_PER_CM = 58;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 3'd4;

  localparam int TRIG_TICKS_W = 8;
  localparam int MAX_PULSE_W  = 16;
  localparam int MAX_DIST_W   = 11;
  localparam int ZONE_WIDTH_W = 10;
  localparam int HYST_W       = 10;
  localparam int ZONE_W       = 8;
  localparam int DIST_OUT_W   = 11;
  localparam int PROD_Z_W     = ZONE_W + ZONE_WIDTH_W;

  localparam int DIST_OUT_MAX = 2047;

  localparam logic [TRIG_TICKS_W-1:0] TRIGGER_TICKS_RST = 8'd10;
  localparam logic [MAX_PULSE_W-1:0]  MAX_PULSE_RST     = 16'd23200;
  localparam logic [MAX_DIST_W-1:0]   MAX_DISTANCE_RST  = 11'd400;
  localparam logic [ZONE_WIDTH_W-1:0] ZONE_WIDTH_RST    = 10'd50;
  localparam logic [HYST_W-1:0]       HYSTERESIS_RST    = 10'd10;

  typedef struct packed {
    logic trig;
    logic done;
  } seq_ctl_t;

endpackage

>>> design/urzt_seq.sv
// ----------------------------------------------------------------------------
// Ultrasonic range zone tracker - measurement sequencer
// Drives the trigger pulse, waits for the echo and times its high period.
// Reports the echo width on the tick the echo falls.
// ----------------------------------------------------------------------------
module urzt_seq #(
  parameter int COUNT_BITS = urzt_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic                                start_req,
  input  logic                                echo,
  input  logic [urzt_pkg::TRIG_TICKS_W-1:0]   trigger_ticks,
  output urzt_pkg::seq_ctl_t                  ctl,
  output logic [COUNT_BITS-1:0]               width
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_HIGH
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [COUNT_BITS-1:0]   trig_len;

  // A pulse length of zero behaves as a single tick.
  assign trig_len  = (trigger_ticks == '0) ? COUNT_BITS'(1) : COUNT_BITS'(trigger_ticks);
  assign count_inc = (count_r == '1) ? count_r : count_r + COUNT_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    ctl       = '0;
    width     = count_inc;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          ctl.trig  = 1'b1;
          count_nxt = COUNT_BITS'(1);
          phase_nxt = (trig_len == COUNT_BITS'(1)) ? PH_WAIT : PH_TRIG;
        end
      end
      PH_TRIG: begin
        ctl.trig = 1'b1;
        if (count_inc >= trig_len) begin
          phase_nxt = PH_WAIT;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          count_nxt = COUNT_BITS'(1);
          phase_nxt = PH_HIGH;
        end
      end
      PH_HIGH: begin
        // The falling tick is counted into the width as well.
        if (!echo) begin
          ctl.done  = 1'b1;
          count_nxt = '0;
          phase_nxt = PH_IDLE;
        end else begin
          count_nxt = count_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/urzt_zone.sv
// ----------------------------------------------------------------------------
// Ultrasonic range zone tracker - hysteretic zone register
// Holds the distance zone; each measurement steps it by one, with a margin
// either side of the boundaries, or clears it when out of range or too far.
// ----------------------------------------------------------------------------
module urzt_zone #(
  parameter int COUNT_BITS = urzt_pkg::COUNT_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              upd,
  input  logic                                              oor,
  input  logic [COUNT_BITS-$clog2(urzt_pkg::US_PER_CM):0]   dist_cm,
  input  logic [urzt_pkg::PROD_Z_W-1:0]                     prod_z,
  input  logic [urzt_pkg::MAX_DIST_W-1:0]                   max_distance,
  input  logic [urzt_pkg::ZONE_WIDTH_W-1:0]                 zone_width,
  input  logic [urzt_pkg::HYST_W-1:0]                       hysteresis,
  output logic [urzt_pkg::ZONE_W-1:0]                       zone_now
);

  localparam int DIST_W = COUNT_BITS - $clog2(urzt_pkg::US_PER_CM) + 1;
  localparam int CW     = ((DIST_W > urzt_pkg::PROD_Z_W) ? DIST_W : urzt_pkg::PROD_Z_W) + 2;

  logic [urzt_pkg::ZONE_W-1:0] zone_r, zone_nxt;
  logic [CW-1:0]               dist_x, up_x, down_x;
  logic                        far, step_up, step_down;

  // prod_z is zone * zone_width. Leaving downwards needs
  // dist_cm < (zone-1)*zone_width - hysteresis, rearranged to stay unsigned;
  // with the zone at zero the product is zero and the test never fires.
  assign dist_x    = CW'(dist_cm);
  assign up_x      = CW'(prod_z) + CW'(hysteresis);
  assign down_x    = dist_x + CW'(hysteresis) + CW'(zone_width);
  assign far       = dist_x > CW'(max_distance);
  assign step_up   = dist_x > up_x;
  assign step_down = down_x < CW'(prod_z);

  always_comb begin
    zone_nxt = zone_r;
    if (oor || far) begin
      zone_nxt = '0;
    end else if (step_up) begin
      if (zone_r != '1) begin
        zone_nxt = zone_r + urzt_pkg::ZONE_W'(1);
      end
    end else if (step_down) begin
      zone_nxt = zone_r - urzt_pkg::ZONE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (upd) begin
      zone_r <= zone_nxt;
    end
  end

  assign zone_now = zone_r;

endmodule

>>> design/ultrasonic_range_zone_tracker_unit.sv
// ----------------------------------------------------------------------------
// Ultrasonic range zone tracker
// Each input beat is one microsecond tick carrying a start request and the
// sampled echo level. Every input beat yields exactly one result beat with
// the trigger level for that tick, a completion flag, the distance in cm,
// an out-of-range flag and the hysteretic distance zone.
//
// The configuration port writes one register per cycle on cfg_we; it is
// meant to be used while no measurement is in flight.
// A three-stage pipeline sits between the channels: the sequencer state
// updates as a beat is taken, the next stage divides the echo width by 58
// through a reciprocal multiply, and the last stage updates the zone and
// loads the output register. One beat is taken every cycle while in_stall
// is low.
// When out_stall is high the output register holds its beat; empty stages
// still fill, so in_stall rises only once all three stages are occupied.
// Synchronous reset empties the pipeline, returns the sequencer to idle,
// clears the zone and restores the register defaults.
// ----------------------------------------------------------------------------
`include "ultrasonic_range_zone_tracker_unit_assert.svh"

module ultrasonic_range_zone_tracker_unit #(
  parameter int COUNT_BITS = urzt_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [urzt_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [urzt_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_start_req,
  input  logic                                   in_echo,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_trigger,
  output logic                                   out_done_res,
  output logic [urzt_pkg::DIST_OUT_W-1:0]        out_distance_cm,
  output logic                                   out_out_of_range,
  output logic [urzt_pkg::ZONE_W-1:0]            out_zone
);

  localparam int SH     = COUNT_BITS + $clog2(urzt_pkg::US_PER_CM);
  localparam int RW     = COUNT_BITS + 1;
  localparam int DIST_W = COUNT_BITS - $clog2(urzt_pkg::US_PER_CM) + 1;
  localparam int QW     = COUNT_BITS + RW;
  localparam int OW     = (COUNT_BITS > urzt_pkg::MAX_PULSE_W) ? COUNT_BITS
                                                               : urzt_pkg::MAX_PULSE_W;
  localparam int DXW    = (DIST_W > urzt_pkg::DIST_OUT_W) ? DIST_W
                                                          : urzt_pkg::DIST_OUT_W + 1;
  // Rounded-up reciprocal: exact for every width below 2**COUNT_BITS.
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + urzt_pkg::US_PER_CM - 1) / urzt_pkg::US_PER_CM;
  localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];

  // Configuration registers
  logic [urzt_pkg::TRIG_TICKS_W-1:0] trigger_ticks_r;
  logic [urzt_pkg::MAX_PULSE_W-1:0]  max_pulse_r;
  logic [urzt_pkg::MAX_DIST_W-1:0]   max_distance_r;
  logic [urzt_pkg::ZONE_WIDTH_W-1:0] zone_width_r;
  logic [urzt_pkg::HYST_W-1:0]       hysteresis_r;

  // Pipeline handshake
  logic acc, s1_rdy, s2_rdy, out_rdy, zone_upd;

  // Stage 1: sequencer output
  urzt_pkg::seq_ctl_t      seq_ctl;
  logic [COUNT_BITS-1:0]   seq_width;
  logic                    s1_v_r;
  urzt_pkg::seq_ctl_t      s1_ctl_r;
  logic [COUNT_BITS-1:0]   s1_width_r;

  // Stage 2: quotient and zone product
  logic [QW-1:0]                    quo_prod;
  logic                             s2_v_r;
  urzt_pkg::seq_ctl_t               s2_ctl_r;
  logic                             s2_oor_r;
  logic [DIST_W-1:0]                s2_dist_r;
  logic [urzt_pkg::PROD_Z_W-1:0]    s2_prod_r;
  logic [DXW-1:0]                   dist_x;
  logic [urzt_pkg::ZONE_W-1:0]      zone_now;

  // Output register
  logic                             out_valid_r;
  logic                             out_trigger_r;
  logic                             out_done_res_r;
  logic [urzt_pkg::DIST_OUT_W-1:0]  out_distance_cm_r;
  logic                             out_out_of_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= urzt_pkg::TRIGGER_TICKS_RST;
      max_pulse_r     <= urzt_pkg::MAX_PULSE_RST;
      max_distance_r  <= urzt_pkg::MAX_DISTANCE_RST;
      zone_width_r    <= urzt_pkg::ZONE_WIDTH_RST;
      hysteresis_r    <= urzt_pkg::HYSTERESIS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        urzt_pkg::CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[urzt_pkg::TRIG_TICKS_W-1:0];
        urzt_pkg::CFG_MAX_PULSE:     max_pulse_r     <= cfg_wdata[urzt_pkg::MAX_PULSE_W-1:0];
        urzt_pkg::CFG_MAX_DISTANCE:  max_distance_r  <= cfg_wdata[urzt_pkg::MAX_DIST_W-1:0];
        urzt_pkg::CFG_ZONE_WIDTH:    zone_width_r    <= cfg_wdata[urzt_pkg::ZONE_WIDTH_W-1:0];
        urzt_pkg::CFG_HYSTERESIS:    hysteresis_r    <= cfg_wdata[urzt_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when it is empty or its successor moves on.
  assign out_rdy  = !out_valid_r || !out_stall;
  assign s2_rdy   = !s2_v_r || out_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign acc      = in_valid && s1_rdy;
  assign zone_upd = out_rdy && s2_v_r && s2_ctl_r.done;

  urzt_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .start_req     (in_start_req),
    .echo          (in_echo),
    .trigger_ticks (trigger_ticks_r),
    .ctl           (seq_ctl),
    .width         (seq_width)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r   <= seq_ctl;
      s1_width_r <= seq_width;
    end
  end

  assign quo_prod = QW'(s1_width_r) * QW'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  // Measurements are at least three beats apart, so the zone read here
  // already includes the previous measurement's update.
  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_ctl_r  <= s1_ctl_r;
      s2_oor_r  <= OW'(s1_width_r) > OW'(max_pulse_r);
      s2_dist_r <= quo_prod[SH +: DIST_W];
      s2_prod_r <= urzt_pkg::PROD_Z_W'(zone_now) * urzt_pkg::PROD_Z_W'(zone_width_r);
    end
  end

  urzt_zone #(
    .COUNT_BITS (COUNT_BITS)
  ) u_zone (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (zone_upd),
    .oor          (s2_oor_r),
    .dist_cm      (s2_dist_r),
    .prod_z       (s2_prod_r),
    .max_distance (max_distance_r),
    .zone_width   (zone_width_r),
    .hysteresis   (hysteresis_r),
    .zone_now     (zone_now)
  );

  assign dist_x = DXW'(s2_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s2_v_r) begin
      out_trigger_r      <= s2_ctl_r.trig;
      out_done_res_r     <= s2_ctl_r.done;
      out_out_of_range_r <= s2_ctl_r.done && s2_oor_r;
      if (!s2_ctl_r.done) begin
        out_distance_cm_r <= '0;
      end else if (dist_x > DXW'(urzt_pkg::DIST_OUT_MAX)) begin
        out_distance_cm_r <= urzt_pkg::DIST_OUT_W'(urzt_pkg::DIST_OUT_MAX);
      end else begin
        out_distance_cm_r <= dist_x[urzt_pkg::DIST_OUT_W-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trigger      = out_trigger_r;
  assign out_done_res     = out_done_res_r;
  assign out_distance_cm  = out_distance_cm_r;
  assign out_out_of_range = out_out_of_range_r;
  assign out_zone         = zone_now;

  // Two completed measurements must never sit in neighbouring stages.
  `URZT_ASSERT_NEVER(a_done_s1_s2, s1_v_r && s1_ctl_r.done && s2_v_r && s2_ctl_r.done, "two measurements in stages 1 and 2")
  `URZT_ASSERT_NEVER(a_done_s2_out, s2_v_r && s2_ctl_r.done && out_valid_r && out_done_res_r, "two measurements in stage 2 and output")
  `URZT_ASSERT_IMP(a_idle_zero, out_valid_r && !out_done_res_r, (out_distance_cm_r == '0) && !out_out_of_range_r, "measurement fields set on a beat without completion")
  `URZT_ASSERT_NEXT(a_zone_hold, !zone_upd, $stable(zone_now), "zone changed without a completed measurement")

endmodule

>>> tb/sv/tb_ultrasonic_range_zone_tracker_unit.sv
// ----------------------------------------------------------------------------
// Ultrasonic range zone tracker - self-checking testbench
// Drives microsecond tick beats (start request and echo level) into the block
// and compares every result beat with a cycle-true model of the ranger kept
// here: trigger pulse, echo width count, distance, range flag and the
// hysteretic zone. Register settings change between bursts of measurements,
// and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_zone_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import urzt_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 4000000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 48;
  localparam int          RANDOM_SETTINGS = 3;
  localparam logic [COUNT_BITS_DEF-1:0] ECHO_COUNT_MAX = '1;

  typedef enum logic [1:0] {
    RG_IDLE,
    RG_TRIGGER,
    RG_WAIT_ECHO,
    RG_ECHO_HIGH
  } ranger_phase_e;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic                  trigger;
    logic                  done;
    logic [DIST_OUT_W-1:0] distance_cm;
    logic                  out_of_range;
    logic [ZONE_W-1:0]     zone;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_start_req = 1'b0;
  logic                  in_echo = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_trigger;
  logic                  out_done_res;
  logic [DIST_OUT_W-1:0] out_distance_cm;
  logic                  out_out_of_range;
  logic [ZONE_W-1:0]     out_zone;

  // Register copies used by the ranger model.
  logic [TRIG_TICKS_W-1:0] trig_ticks_q = TRIGGER_TICKS_RST;
  logic [MAX_PULSE_W-1:0]  max_pulse_q = MAX_PULSE_RST;
  logic [MAX_DIST_W-1:0]   max_dist_q = MAX_DISTANCE_RST;
  logic [ZONE_WIDTH_W-1:0] zone_width_q = ZONE_WIDTH_RST;
  logic [HYST_W-1:0]       hyst_q = HYSTERESIS_RST;

  // Ranger model state.
  ranger_phase_e             ph_q = RG_IDLE;
  logic [COUNT_BITS_DEF-1:0] count_q = '0;
  logic [ZONE_W-1:0]         zone_q = '0;

  tick_t       tick_backlog[$];
  reading_t    expected_readings[$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned pings_done = 0;
  int unsigned settings_used = 0;
  int unsigned zone_peak = 0;
  logic        beat_taken = 1'b0;
  logic        quiet_tail = 1'b0;
  int unsigned hold_asks = 0;

  ultrasonic_range_zone_tracker_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_req     (in_start_req),
    .in_echo          (in_echo),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_trigger      (out_trigger),
    .out_done_res     (out_done_res),
    .out_distance_cm  (out_distance_cm),
    .out_out_of_range (out_out_of_range),
    .out_zone         (out_zone)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned trigger_len();
    return (trig_ticks_q == '0) ? 1 : trig_ticks_q;
  endfunction

  function automatic logic [ZONE_W-1:0] stepped_zone(int unsigned cm, logic oor);
    longint d, z, zw, hy, up, down;
    d = cm;
    z = zone_q;
    zw = zone_width_q;
    hy = hyst_q;
    up = z * zw + hy;
    down = (z - 1) * zw - hy;
    if (oor || cm > max_dist_q) return '0;
    if (d > up) return (zone_q == '1) ? zone_q : zone_q + 1'b1;
    if (d < down) return (zone_q == '0) ? zone_q : zone_q - 1'b1;
    return zone_q;
  endfunction

  // One microsecond tick of the ranger: updates the model and gives the reading.
  task automatic advance_ranger(input tick_t t, output reading_t r);
    int unsigned width;
    int unsigned cm;
    logic        oor;
    r = '0;
    case (ph_q)
      RG_IDLE: begin
        if (t.start_req) begin
          r.trigger = 1'b1;
          count_q = 1;
          ph_q = (count_q >= trigger_len()) ? RG_WAIT_ECHO : RG_TRIGGER;
        end
      end
      RG_TRIGGER: begin
        r.trigger = 1'b1;
        if (count_q != ECHO_COUNT_MAX) count_q++;
        if (count_q >= trigger_len()) begin
          ph_q = RG_WAIT_ECHO;
          count_q = '0;
        end
      end
      RG_WAIT_ECHO: begin
        if (t.echo) begin
          count_q = 1;
          ph_q = RG_ECHO_HIGH;
        end
      end
      default: begin
        if (count_q != ECHO_COUNT_MAX) count_q++;
        if (!t.echo) begin
          width = count_q;
          cm = width / US_PER_CM;
          oor = width > max_pulse_q;
          r.done = 1'b1;
          r.distance_cm = (cm > DIST_OUT_MAX) ? DIST_OUT_MAX : cm;
          r.out_of_range = oor;
          zone_q = stepped_zone(cm, oor);
          count_q = '0;
          ph_q = RG_IDLE;
          pings_done++;
          if (zone_q > zone_peak) zone_peak = zone_q;
        end
      end
    endcase
    r.zone = zone_q;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked first, then the accepted tick is run through the model.
  always @(posedge clk) begin : score
    reading_t got;
    reading_t want;
    reading_t pred;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ultrasonic_range_zone_tracker_unit");
      $finish;
    end else if (!rst_n) begin
      beat_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.trigger = out_trigger;
        got.done = out_done_res;
        got.distance_cm = out_distance_cm;
        got.out_of_range = out_out_of_range;
        got.zone = out_zone;
        if (expected_readings.size() == 0) begin
          $error("result beat arrived with no reading expected");
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("trigger", want.trigger, got.trigger);
          check_field("done_res", want.done, got.done);
          check_field("distance_cm", want.distance_cm, got.distance_cm);
          check_field("out_of_range", want.out_of_range, got.out_of_range);
          check_field("zone", want.zone, got.zone);
        end
      end
      beat_taken = in_valid && !in_stall;
      if (beat_taken) begin
        advance_ranger(tick_t'({in_start_req, in_echo}), pred);
        expected_readings.push_back(pred);
        beats_taken++;
      end
    end
  end

  always @(negedge clk) begin : drive_ticks
    tick_t       nxt;
    logic        offer;
    int unsigned gap_left;
    if (rst_n && (!in_valid || beat_taken)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (tick_backlog.size() > 0) begin
        nxt = tick_backlog.pop_front();
        offer = 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 5);
      end
      in_valid <= offer;
      if (offer) begin
        in_start_req <= nxt.start_req;
        in_echo <= nxt.echo;
      end
    end
  end

  always @(negedge clk) begin : drive_stall
    int unsigned hold_left;
    int unsigned hold_served;
    int unsigned stall_left;
    logic        s;
    s = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end else if (hold_served != hold_asks) begin
      // A long hold-off lets the pipeline fill so that the input side stalls.
      hold_served++;
      hold_left = HOLD_OFF_CYCLES - 1;
      s = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      s = 1'b1;
    end else if (rst_n && !quiet_tail && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      s = 1'b1;
    end
    out_stall <= s;
  end

  task automatic push_tick(input logic s, input logic e);
    tick_t t;
    t.start_req = s;
    t.echo = e;
    tick_backlog.push_back(t);
    beats_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beats_taken != beats_queued || expected_readings.size() != 0);
  endtask

  // Brings the ranger back to idle so that registers can be rewritten safely.
  task automatic settle_ranger();
    wait_drained();
    while (ph_q != RG_IDLE) begin
      push_tick(1'b0, ph_q == RG_WAIT_ECHO);
      wait_drained();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TRIGGER_TICKS: trig_ticks_q = val[TRIG_TICKS_W-1:0];
      CFG_MAX_PULSE:     max_pulse_q = val[MAX_PULSE_W-1:0];
      CFG_MAX_DISTANCE:  max_dist_q = val[MAX_DIST_W-1:0];
      CFG_ZONE_WIDTH:    zone_width_q = val[ZONE_WIDTH_W-1:0];
      CFG_HYSTERESIS:    hyst_q = val[HYST_W-1:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry random junk that the block must drop.
  task automatic configure_ranger(input int trig, input int pulse, input int maxd,
                                  input int zw, input int hys);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_TRIGGER_TICKS, {junk[CFG_DATA_W-1:TRIG_TICKS_W], trig[TRIG_TICKS_W-1:0]});
    write_reg(CFG_MAX_PULSE, pulse[MAX_PULSE_W-1:0]);
    junk = $urandom;
    write_reg(CFG_MAX_DISTANCE, {junk[CFG_DATA_W-1:MAX_DIST_W], maxd[MAX_DIST_W-1:0]});
    junk = $urandom;
    write_reg(CFG_ZONE_WIDTH, {junk[CFG_DATA_W-1:ZONE_WIDTH_W], zw[ZONE_WIDTH_W-1:0]});
    junk = $urandom;
    write_reg(CFG_HYSTERESIS, {junk[CFG_DATA_W-1:HYST_W], hys[HYST_W-1:0]});
    for (int i = CFG_HYSTERESIS + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One measurement: start tick, the rest of the trigger, a wait, the echo pulse.
  task automatic queue_ping(input int width, input int wait_ticks);
    push_tick(1'b1, $urandom);
    for (int i = 1; i < trigger_len(); i++) push_tick($urandom, $urandom);
    repeat (wait_ticks) push_tick($urandom, 1'b0);
    repeat (width) push_tick($urandom, 1'b1);
    push_tick($urandom, 1'b0);
  endtask

  task automatic queue_random_ping();
    int width;
    case ($urandom_range(0, 9))
      0: width = $urandom_range(1, 3);
      1: width = $urandom_range(200, 700);
      default: begin
        width = $urandom_range(0, 2) * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
        if (width == 0) width = 1;
      end
    endcase
    queue_ping(width, $urandom_range(0, 4));
  endtask

  initial begin : stimulus
    int          n;
    int          pings;
    int          trig, pulse, maxd, zw, hys;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: shortest echo, two echoes that give one centimetre, and an
    // echo seen while idle without a start request.
    queue_ping(1, 0);
    queue_ping(57, 2);
    queue_ping(58, 1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    settle_ranger();

    // Zero trigger length, two echoes just above max_pulse, and distances exactly
    // at max_distance.
    configure_ranger(0, 116, 1, 1, 0);
    queue_ping(116, 0);
    queue_ping(117, 1);
    queue_ping(58, 0);
    queue_ping(58, 2);
    settle_ranger();

    // Zero zone width and hysteresis: every ping of 1 cm climbs one zone.
    configure_ranger(1, 65535, 2047, 0, 0);
    repeat (4) queue_ping(US_PER_CM, 0);
    settle_ranger();

    // Stepping back down from a higher zone, then one step up again.
    configure_ranger(3, 65535, 2047, 1, 0);
    repeat (4) queue_ping(10, 1);
    queue_ping(120, 0);
    settle_ranger();

    for (int k = 0; k < RANDOM_SETTINGS; k++) begin
      trig = (k == 0) ? 255 : (k == 1) ? 1 : $urandom_range(0, 12);
      pulse = (k == 0) ? 65535 : (k == 1) ? 0 :
              ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 1000);
      maxd = (k == 0) ? 2047 : (k == 1) ? 0 :
             ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(0, 20);
      zw = (k == 0) ? 1023 : (k == 1) ? 1 : $urandom_range(0, 4);
      hys = (k == 0) ? 1023 : (k == 1) ? 0 : $urandom_range(0, 2);
      configure_ranger(trig, pulse, maxd, zw, hys);
      if (k >= RANDOM_SETTINGS - 1) quiet_tail = 1'b1;
      if (k == 1) hold_asks++;
      pings = (k == 0) ? 1 : 2;
      n = 0;
      while (n < pings) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 6)) push_tick($urandom, $urandom);
        end
        queue_random_ping();
        n++;
        if (k == RANDOM_SETTINGS - 1 && n == 1) wait_drained();
      end
      settle_ranger();
    end

    $display("Run covered %0d completed measurements in %0d tick beats under %0d settings.",
             pings_done, beats_taken, settings_used + 1);
    $display("Highest zone reached: %0d.", zone_peak);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("PASS ultrasonic_range_zone_tracker_unit");
    end else begin
      $display("FAIL ultrasonic_range_zone_tracker_unit");
    end
    $finish;
  end

endmodule
